>>> hw/rtl/grwi_pkg.sv
// ----------------------------------------------------------------------------
// grwi_pkg
// Shared types, constants and the tangent / cotangent table builder for the
// grid ray wall intersection block.
// ----------------------------------------------------------------------------
package grwi_pkg;

   localparam int ANGLE_STEPS = 1024;
   localparam int ANGLE_W     = 10;
   localparam int POS_W       = 17;
   localparam int COORD_W     = 24;
   localparam int TRIG_W      = 32;
   localparam int SUM_W       = 34;
   localparam int TILE_SHIFT  = 14;
   localparam int MAP_W       = 64;

   localparam longint PI_Q30     = 64'sd3373259426;
   localparam longint ONE_Q30    = 64'sd1073741824;
   localparam longint TRIG_LIMIT = 64'sd2147483647;

   localparam logic signed [SUM_W-1:0] COORD_MAX = 34'sd8388607;
   localparam logic signed [SUM_W-1:0] COORD_MIN = -34'sd8388608;

   // one pass of the march: point, step, status
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [TRIG_W-1:0]  dx;
      logic signed [TRIG_W-1:0]  dy;
      logic                      hit;
      logic                      done;
   } pass_type;

   // tan in the upper half, cot in the lower half, both Q16
   typedef logic [2*TRIG_W-1:0] trig_table_type [ANGLE_STEPS];

   function automatic logic signed [COORD_W-1:0] clamp_coord(
      input logic signed [SUM_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > COORD_MAX) begin
         r = COORD_MAX[COORD_W-1:0];
      end else if (v < COORD_MIN) begin
         r = COORD_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   // signed quotient truncated toward zero, shift and subtract on magnitudes
   function automatic longint div_trunc(input longint num, input longint den);
      logic [63:0] n_mag;
      logic [63:0] d_mag;
      logic [63:0] q;
      logic [63:0] rem;
      logic        neg;
      neg   = (num < 0) != (den < 0);
      n_mag = (num < 0) ? -num : num;
      d_mag = (den < 0) ? -den : den;
      q     = '0;
      rem   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], n_mag[i]};
         if (rem >= d_mag) begin
            rem  = rem - d_mag;
            q[i] = 1'b1;
         end
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint ratio_q16(input longint num, input longint den);
      longint r;
      if (den == 0) begin
         r = (num < 0) ? -TRIG_LIMIT : TRIG_LIMIT;
      end else begin
         r = div_trunc(num * 65536, den);
         if (r > TRIG_LIMIT) r = TRIG_LIMIT;
         if (r < -TRIG_LIMIT) r = -TRIG_LIMIT;
      end
      return r;
   endfunction

   function automatic logic [2*TRIG_W-1:0] trig_entry(input longint k);
      longint x;
      longint s;
      longint c;
      longint ts;
      longint tc;
      longint t;
      longint cot;
      logic   neg_cos;
      x = (2 * PI_Q30 * k) / ANGLE_STEPS;
      neg_cos = 1'b0;
      if (x > PI_Q30) x = x - 2 * PI_Q30;
      if (x > PI_Q30 / 2) begin
         x = PI_Q30 - x;
         neg_cos = 1'b1;
      end else if (x < -(PI_Q30 / 2)) begin
         x = -PI_Q30 - x;
         neg_cos = 1'b1;
      end
      s  = x;
      ts = x;
      c  = ONE_Q30;
      tc = ONE_Q30;
      for (int n = 1; n <= 10; n++) begin
         ts = div_trunc(-((ts * x) / ONE_Q30), longint'((2 * n) * (2 * n + 1)));
         tc = div_trunc(-((tc * x) / ONE_Q30), longint'((2 * n - 1) * (2 * n)));
         s  = s + ts;
         c  = c + tc;
      end
      if (neg_cos) c = -c;
      t   = ratio_q16(s, c);
      cot = ratio_q16(c, s);
      return {t[TRIG_W-1:0], cot[TRIG_W-1:0]};
   endfunction

   function automatic trig_table_type build_trig_table();
      trig_table_type tbl;
      for (int k = 0; k < ANGLE_STEPS; k++) begin
         tbl[k] = trig_entry(longint'(k));
      end
      return tbl;
   endfunction

endpackage

>>> hw/rtl/grid_ray_wall_intersection.sv
// ----------------------------------------------------------------------------
// grid_ray_wall_intersection
// Casts one ray against a tile grid in a horizontal-line and a vertical-line
// pass and reports where each pass stopped and whether it met a wall.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries a viewer position and a ray angle; rsp_* returns the stop
//   point and hit flag of both passes, one response transaction per request.
//   csr_* writes the 64-bit wall map (bit ty*GRID_SIZE+tx); it is always ready,
//   and the user must write it only while no ray is in flight; the block does not enforce this.
// Pipeline: the table is read on accept, then multiply, start point, one cell
//   per line crossing, then a hand-off buffer and the output register.
// Only one ray is in flight at a time: req_tready stays low from accept until
//   the ray moves from the hand-off buffer to the output register.
// A new request is taken while a finished response still waits in the output
//   register; if the receiver stalls longer, the next ray parks in the
//   hand-off buffer and req_tready stays low until it moves on.
// Reset clears the wall map to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module grid_ray_wall_intersection #(
   parameter int GRID_SIZE = 8,
   parameter int MAX_STEPS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // pos_x[16:0], pos_y[33:17], angle[43:34], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // horiz_x, horiz_y, horiz_hit, vert_x, vert_y,
                                     // vert_hit from bit 0 up, zero pad
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [63:0]  csr_wdata
);
   import grwi_pkg::*;

   localparam int HALF    = ANGLE_STEPS / 2;
   localparam int QUARTER = ANGLE_STEPS / 4;
   localparam int THREE_Q = 3 * ANGLE_STEPS / 4;
   localparam int PROD_W  = 19 + TRIG_W;
   localparam logic signed [TRIG_W-1:0] STEP_POS = 32'sd16384;
   localparam logic signed [TRIG_W-1:0] STEP_NEG = -32'sd16384;

   logic [MAP_W-1:0] wall_map_ff;
   logic             busy_ff;

   // stage 1: request held while the table is read
   logic                     s1_valid_ff;
   logic [POS_W-1:0]         px_ff, py_ff;
   logic [ANGLE_W-1:0]       k_ff;
   logic signed [TRIG_W-1:0] tan_q16, cot_q16;

   // stage 2: products and start lines
   logic                     s2_valid_ff;
   logic [POS_W-1:0]         px2_ff, py2_ff;
   logic signed [18:0]       hy_ff, vx_ff, hy_in, vx_in, dyh, dxv;
   logic signed [PROD_W-1:0] prod_h_ff, prod_v_ff;
   logic signed [TRIG_W-1:0] step_h_ff, step_v_ff;
   logic                     skip_h_ff, skip_v_ff, neg_h_ff, neg_v_ff;
   logic                     skip_h_in, skip_v_in, neg_h_in, neg_v_in;
   logic [POS_W-1:0]         base_y, base_x;

   pass_type                 chain_h [MAX_STEPS+1];
   pass_type                 chain_v [MAX_STEPS+1];
   logic                     chain_valid [MAX_STEPS+1];
   pass_type                 start_h_in, start_v_in;
   logic signed [SUM_W-1:0]  hx_sum, vy_sum;

   logic                     fin_valid_ff;
   pass_type                 fin_h_ff, fin_v_ff;
   logic                     rsp_valid_ff;
   logic [103:0]             rsp_data_ff;
   logic                     req_accept, fin_move;

   assign csr_ready  = 1'b1;
   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && !busy_ff;
   assign fin_move   = fin_valid_ff && (!rsp_valid_ff || rsp_tready);

   grwi_trig_rom u_trig_rom (
      .clock   (clock),
      .addr    (req_tdata[43:34]),
      .tan_q16 (tan_q16),
      .cot_q16 (cot_q16)
   );

   always_comb begin
      skip_h_in = (k_ff == ANGLE_W'(0)) || (k_ff == ANGLE_W'(HALF));
      neg_h_in  = k_ff > ANGLE_W'(HALF);
      skip_v_in = (k_ff == ANGLE_W'(QUARTER)) || (k_ff == ANGLE_W'(THREE_Q));
      neg_v_in  = (k_ff > ANGLE_W'(QUARTER)) && (k_ff < ANGLE_W'(THREE_Q));
      base_y    = {py_ff[POS_W-1:TILE_SHIFT], {TILE_SHIFT{1'b0}}};
      base_x    = {px_ff[POS_W-1:TILE_SHIFT], {TILE_SHIFT{1'b0}}};
      hy_in     = neg_h_in ? (19'(base_y) - 19'sd1) : (19'(base_y) + 19'sd16384);
      vx_in     = neg_v_in ? (19'(base_x) - 19'sd1) : (19'(base_x) + 19'sd16384);
      dyh       = hy_in - 19'(py_ff);
      dxv       = vx_in - 19'(px_ff);
   end

   always_comb begin
      hx_sum = SUM_W'(prod_h_ff / 51'sd65536) + SUM_W'(px2_ff);
      vy_sum = SUM_W'(prod_v_ff / 51'sd65536) + SUM_W'(py2_ff);
      start_h_in.hit  = 1'b0;
      start_v_in.hit  = 1'b0;
      if (skip_h_ff) begin
         start_h_in.x    = COORD_W'(px2_ff);
         start_h_in.y    = COORD_W'(py2_ff);
         start_h_in.dx   = '0;
         start_h_in.dy   = '0;
         start_h_in.done = 1'b1;
      end else begin
         start_h_in.x    = clamp_coord(hx_sum);
         start_h_in.y    = COORD_W'(hy_ff);
         start_h_in.dx   = step_h_ff;
         start_h_in.dy   = neg_h_ff ? STEP_NEG : STEP_POS;
         start_h_in.done = 1'b0;
      end
      if (skip_v_ff) begin
         start_v_in.x    = COORD_W'(px2_ff);
         start_v_in.y    = COORD_W'(py2_ff);
         start_v_in.dx   = '0;
         start_v_in.dy   = '0;
         start_v_in.done = 1'b1;
      end else begin
         start_v_in.x    = COORD_W'(vx_ff);
         start_v_in.y    = clamp_coord(vy_sum);
         start_v_in.dx   = neg_v_ff ? STEP_NEG : STEP_POS;
         start_v_in.dy   = step_v_ff;
         start_v_in.done = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_map_ff    <= '0;
         busy_ff        <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         chain_valid[0] <= 1'b0;
         fin_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            wall_map_ff <= csr_wdata;
         end
         if (req_accept) begin
            busy_ff <= 1'b1;
         end else if (fin_move) begin
            busy_ff <= 1'b0;
         end
         s1_valid_ff    <= req_accept;
         s2_valid_ff    <= s1_valid_ff;
         chain_valid[0] <= s2_valid_ff;
         if (chain_valid[MAX_STEPS]) begin
            fin_valid_ff <= 1'b1;
         end else if (fin_move) begin
            fin_valid_ff <= 1'b0;
         end
         if (fin_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         px_ff <= req_tdata[16:0];
         py_ff <= req_tdata[33:17];
         k_ff  <= req_tdata[43:34];
      end
      px2_ff     <= px_ff;
      py2_ff     <= py_ff;
      hy_ff      <= hy_in;
      vx_ff      <= vx_in;
      prod_h_ff  <= PROD_W'(dyh) * PROD_W'(cot_q16);
      prod_v_ff  <= PROD_W'(dxv) * PROD_W'(tan_q16);
      step_h_ff  <= neg_h_in ? -(cot_q16 / 32'sd4) : (cot_q16 / 32'sd4);
      step_v_ff  <= neg_v_in ? -(tan_q16 / 32'sd4) : (tan_q16 / 32'sd4);
      skip_h_ff  <= skip_h_in;
      skip_v_ff  <= skip_v_in;
      neg_h_ff   <= neg_h_in;
      neg_v_ff   <= neg_v_in;
      chain_h[0] <= start_h_in;
      chain_v[0] <= start_v_in;
      if (chain_valid[MAX_STEPS]) begin
         fin_h_ff <= chain_h[MAX_STEPS];
         fin_v_ff <= chain_v[MAX_STEPS];
      end
      if (fin_move) begin
         rsp_data_ff <= {6'b0, fin_v_ff.hit, fin_v_ff.y, fin_v_ff.x,
                         fin_h_ff.hit, fin_h_ff.y, fin_h_ff.x};
      end
   end

   for (genvar i = 0; i < MAX_STEPS; i++) begin : g_cell
      grwi_cell #(
         .GRID_SIZE (GRID_SIZE)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wall_map  (wall_map_ff),
         .valid_in  (chain_valid[i]),
         .horiz_in  (chain_h[i]),
         .vert_in   (chain_v[i]),
         .valid_out (chain_valid[i+1]),
         .horiz_out (chain_h[i+1]),
         .vert_out  (chain_v[i+1])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/grwi_trig_rom.sv
// ----------------------------------------------------------------------------
// grwi_trig_rom
// Tangent and cotangent lookup by angle, registered read.
// ----------------------------------------------------------------------------
module grwi_trig_rom (
   input  logic                                     clock,
   input  logic [grwi_pkg::ANGLE_W-1:0]             addr,
   output logic signed [grwi_pkg::TRIG_W-1:0]       tan_q16,
   output logic signed [grwi_pkg::TRIG_W-1:0]       cot_q16
);
   import grwi_pkg::*;

   localparam trig_table_type TRIG_TABLE = build_trig_table();

   logic [2*TRIG_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      rd_ff <= TRIG_TABLE[addr];
   end

   assign tan_q16 = rd_ff[2*TRIG_W-1:TRIG_W];
   assign cot_q16 = rd_ff[TRIG_W-1:0];

endmodule

>>> hw/rtl/grwi_cell.sv
// ----------------------------------------------------------------------------
// grwi_cell
// One line crossing of both passes: tile test against the wall map, then
// either stop on the wall or advance by one step; a finished pass goes through unchanged.
// ----------------------------------------------------------------------------
module grwi_cell #(
   parameter int GRID_SIZE = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [grwi_pkg::MAP_W-1:0]    wall_map,
   input  logic                          valid_in,
   input  grwi_pkg::pass_type            horiz_in,
   input  grwi_pkg::pass_type            vert_in,
   output logic                          valid_out,
   output grwi_pkg::pass_type            horiz_out,
   output grwi_pkg::pass_type            vert_out
);
   import grwi_pkg::*;

   localparam int TILE_W = COORD_W - TILE_SHIFT;

   logic     valid_ff;
   pass_type horiz_ff, horiz_in_next;
   pass_type vert_ff, vert_in_next;

   function automatic pass_type step_pass(input pass_type p, input logic [MAP_W-1:0] map);
      logic signed [TILE_W-1:0] tx;
      logic signed [TILE_W-1:0] ty;
      logic [TILE_W-1:0]        lin;
      logic                     wall;
      pass_type                 r;
      tx   = p.x[COORD_W-1:TILE_SHIFT];
      ty   = p.y[COORD_W-1:TILE_SHIFT];
      lin  = TILE_W'(TILE_W'(ty) * TILE_W'(GRID_SIZE)) + TILE_W'(tx);
      wall = !tx[TILE_W-1] && (tx < GRID_SIZE) && !ty[TILE_W-1] && (ty < GRID_SIZE)
             && map[lin[5:0]];
      r = p;
      if (!p.done) begin
         if (wall) begin
            r.hit  = 1'b1;
            r.done = 1'b1;
         end else begin
            r.x = clamp_coord(SUM_W'(p.x) + SUM_W'(p.dx));
            r.y = clamp_coord(SUM_W'(p.y) + SUM_W'(p.dy));
         end
      end
      return r;
   endfunction

   always_comb begin
      horiz_in_next = step_pass(horiz_in, wall_map);
      vert_in_next  = step_pass(vert_in, wall_map);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      horiz_ff <= horiz_in_next;
      vert_ff  <= vert_in_next;
   end

   assign valid_out = valid_ff;
   assign horiz_out = horiz_ff;
   assign vert_out  = vert_ff;

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid ray wall intersection block: random and
// directed rays against several wall maps, predicted in the bench and compared
// field by field with each response transaction.
// ----------------------------------------------------------------------------
class ray_scoreboard;
   logic [103:0] pending[$];
   int           errors;
   int           checked;

   function void note_ray(logic [103:0] exp_word);
      pending.push_back(exp_word);
   endfunction

   function void report(string what);
      $display("mismatch: %s", what);
      errors++;
   endfunction

   function void check_hit(logic [103:0] got);
      logic [103:0] exp_word;
      if (pending.size() == 0) begin
         report($sformatf("unexpected response %h", got));
         return;
      end
      exp_word = pending.pop_front();
      checked++;
      if (got[23:0] !== exp_word[23:0])
         report($sformatf("horiz_x got %h exp %h", got[23:0], exp_word[23:0]));
      if (got[47:24] !== exp_word[47:24])
         report($sformatf("horiz_y got %h exp %h", got[47:24], exp_word[47:24]));
      if (got[48] !== exp_word[48])
         report($sformatf("horiz_hit got %b exp %b", got[48], exp_word[48]));
      if (got[72:49] !== exp_word[72:49])
         report($sformatf("vert_x got %h exp %h", got[72:49], exp_word[72:49]));
      if (got[96:73] !== exp_word[96:73])
         report($sformatf("vert_y got %h exp %h", got[96:73], exp_word[96:73]));
      if (got[97] !== exp_word[97])
         report($sformatf("vert_hit got %b exp %b", got[97], exp_word[97]));
      if (got[103:98] !== 6'd0)
         report("response pad bits not zero");
   endfunction
endclass

module tb_top;
   import grwi_pkg::*;

   localparam int GRID = 8;
   localparam int STEPS = 8;
   localparam int LIMIT_CYCLES = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [63:0]  csr_wdata = '0;

   ray_scoreboard sb = new();
   logic [63:0] walls;
   longint      tan_tab [ANGLE_STEPS];
   longint      cot_tab [ANGLE_STEPS];
   int          send_idle;
   int          recv_idle;
   bit          hold_off;
   int          cycles;
   int          rays_sent;

   grid_ray_wall_intersection #(.GRID_SIZE(GRID), .MAX_STEPS(STEPS)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint sat_coord(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint q16_div(longint num, longint den);
      longint r;
      if (den == 0) return (num < 0) ? -64'sd2147483647 : 64'sd2147483647;
      r = (num * 65536) / den;
      if (r > 2147483647) r = 2147483647;
      if (r < -2147483647) r = -2147483647;
      return r;
   endfunction

   // series sine / cosine in Q30, folded to the right half plane
   task automatic fill_trig();
      longint x, s, c, ts, tc;
      bit     flip;
      for (int k = 0; k < ANGLE_STEPS; k++) begin
         x = (2 * PI_Q30 * longint'(k)) / ANGLE_STEPS;
         flip = 0;
         if (x > PI_Q30) x -= 2 * PI_Q30;
         if (x > PI_Q30 / 2) begin
            x = PI_Q30 - x;
            flip = 1;
         end else if (x < -(PI_Q30 / 2)) begin
            x = -PI_Q30 - x;
            flip = 1;
         end
         s = x; ts = x; c = ONE_Q30; tc = ONE_Q30;
         for (int n = 1; n <= 10; n++) begin
            ts = (-((ts * x) / ONE_Q30)) / longint'((2 * n) * (2 * n + 1));
            tc = (-((tc * x) / ONE_Q30)) / longint'((2 * n - 1) * (2 * n));
            s += ts;
            c += tc;
         end
         if (flip) c = -c;
         tan_tab[k] = q16_div(s, c);
         cot_tab[k] = q16_div(c, s);
      end
   endtask

   function automatic longint tile_idx(longint v);
      if (v >= 0) return v >>> 14;
      return -1 - ((-1 - v) >>> 14);
   endfunction

   function automatic bit walk_grid(ref longint x, ref longint y, input longint dx,
                                    input longint dy);
      longint tx, ty;
      for (int i = 0; i < STEPS; i++) begin
         tx = tile_idx(x);
         ty = tile_idx(y);
         if (tx >= 0 && tx < GRID && ty >= 0 && ty < GRID)
            if (walls[(ty * GRID + tx) & 63]) return 1;
         x = sat_coord(x + dx);
         y = sat_coord(y + dy);
      end
      return 0;
   endfunction

   function automatic logic [103:0] cast_ray(logic [16:0] ux, logic [16:0] uy,
                                             logic [9:0] ang);
      longint px, py, hx, hy, vx, vy, d, tq, cq, k;
      bit     hh, vh;
      px = ux; py = uy; k = ang;
      tq = tan_tab[k];
      cq = cot_tab[k];
      hx = px; hy = py; hh = 0;
      if (!(2 * k == 0 || 2 * k == ANGLE_STEPS)) begin
         if (2 * k > ANGLE_STEPS) begin
            hy = (py & ~64'sd16383) - 1; d = -16384;
         end else begin
            hy = (py & ~64'sd16383) + 16384; d = 16384;
         end
         hx = sat_coord(px + ((hy - py) * cq) / 65536);
         hh = walk_grid(hx, hy, (d * cq) / 65536, d);
      end
      vx = px; vy = py; vh = 0;
      if (!(4 * k == ANGLE_STEPS || 4 * k == 3 * ANGLE_STEPS)) begin
         if (4 * k > ANGLE_STEPS && 4 * k < 3 * ANGLE_STEPS) begin
            vx = (px & ~64'sd16383) - 1; d = -16384;
         end else begin
            vx = (px & ~64'sd16383) + 16384; d = 16384;
         end
         vy = sat_coord(py + ((vx - px) * tq) / 65536);
         vh = walk_grid(vx, vy, d, (d * tq) / 65536);
      end
      return {6'd0, vh, vy[23:0], vx[23:0], hh, hy[23:0], hx[23:0]};
   endfunction

   task automatic send_ray(logic [16:0] ux, logic [16:0] uy, logic [9:0] ang);
      // req_tvalid goes low after the previous transaction, with random idle before offering the next
      @(posedge clock);
      while ($urandom_range(99) < send_idle) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, ang, uy, ux};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_ray(cast_ray(ux, uy, ang));
      rays_sent++;
      req_tvalid <= 1'b0;
   endtask

   task automatic write_walls(logic [63:0] m);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (STEPS + 8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      walls = m;
   endtask

   // positions across the whole grid from two random sources; a 17-bit position never lies outside it
   task automatic random_rays(int count);
      logic [16:0] x, y;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 8) begin
            x = 17'($urandom_range(131071));
            y = 17'($urandom_range(131071));
         end else begin
            x = 17'($urandom);
            y = 17'($urandom);
         end
         send_ray(x, y, 10'($urandom));
      end
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_hit(rsp_tdata);
      if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      walls = '0;
      fill_trig();
      send_idle = 8;
      recv_idle = 83;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: axis angles, extreme positions, empty map first
      send_ray(17'd0, 17'd0, 10'd0);
      send_ray(17'h1ffff, 17'h1ffff, 10'd256);
      send_ray(17'd8192, 17'd8192, 10'd512);
      send_ray(17'd100, 17'd100, 10'd768);
      write_walls(64'hffff_ffff_ffff_ffff);
      send_ray(17'd0, 17'd0, 10'd0);
      send_ray(17'd0, 17'd0, 10'd256);
      send_ray(17'd16384, 17'd16384, 10'd512);
      send_ray(17'd40000, 17'd40000, 10'd768);
      send_ray(17'd1000, 17'd2000, 10'd1);
      send_ray(17'd1000, 17'd2000, 10'd1023);
      send_ray(17'd70000, 17'd70000, 10'd128);
      send_ray(17'h1ffff, 17'd0, 10'd384);
      send_ray(17'd0, 17'h1ffff, 10'd640);
      send_ray(17'd130000, 17'd130000, 10'd255);
      write_walls(64'h8100_0000_0000_0081);
      send_ray(17'd40000, 17'd40000, 10'd128);
      send_ray(17'd40000, 17'd40000, 10'd384);
      send_ray(17'd40000, 17'd40000, 10'd640);
      send_ray(17'd40000, 17'd40000, 10'd896);
      send_ray(17'd65535, 17'd65536, 10'd257);
      send_ray(17'd16383, 17'd16383, 10'd511);

      write_walls({$urandom, $urandom} & {$urandom, $urandom});
      random_rays(200);

      // stall the receiver for a long stretch while rays keep coming
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         random_rays(20);
      join

      send_idle = 83;
      recv_idle = 8;
      write_walls({$urandom, $urandom});
      random_rays(180);

      send_idle = 0;
      recv_idle = 0;
      write_walls(64'h0000_0000_0000_0001);
      random_rays(100);
      write_walls({$urandom, $urandom} | {$urandom, $urandom});
      random_rays(100);

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (STEPS + 20) @(posedge clock);
      $display("covered %0d rays, %0d responses checked, seven wall maps incl. empty and full",
               rays_sent, sb.checked);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("status: fail");
      end
      $finish;
   end
endmodule

>>> sim.f
hw/rtl/grwi_pkg.sv
hw/rtl/grwi_trig_rom.sv
hw/rtl/grwi_cell.sv
hw/rtl/grid_ray_wall_intersection.sv
verif/tb_top.sv
